>>> rtl/core/mfsq_pkg.sv
// ----------------------------------------------------------------------------
// mfsq_pkg
// Shared sizes, register indexes and result codes of the marker frame
// splitter queue.
// ----------------------------------------------------------------------------
package mfsq_pkg;

	localparam int SLOT_COUNT = 16;
	localparam int SLOT_BYTES = 256;

	localparam int STORE_SIZE = SLOT_COUNT * SLOT_BYTES;
	localparam int ADDR_W     = $clog2(STORE_SIZE);
	localparam int SLOT_W     = $clog2(SLOT_COUNT);
	localparam int OFF_W      = $clog2(SLOT_BYTES);
	localparam int LEN_W      = $clog2(SLOT_BYTES + 1);
	localparam int CNT_W      = $clog2(SLOT_COUNT + 1);

	localparam int WAITING_W  = 5;
	localparam int CFG_ADDR_W = 1;
	localparam int CFG_DATA_W = 8;

	localparam logic [CFG_ADDR_W-1:0] REG_START_MARKER = 1'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_END_MARKER   = 1'd1;

	localparam logic [7:0] START_MARKER_RESET = 8'd62;
	localparam logic [7:0] END_MARKER_RESET   = 8'd90;

	typedef enum logic [2:0] {
		ST_IGNORED    = 3'd0,
		ST_TAKEN      = 3'd1,
		ST_STORED     = 3'd2,
		ST_DROP_LONG  = 3'd3,
		ST_DROP_FULL  = 3'd4,
		ST_READ_BYTE  = 3'd5,
		ST_READ_EMPTY = 3'd6
	} status_t;

	typedef struct packed {
		status_t              status;
		logic [7:0]           data;
		logic                 frame_end;
		logic [WAITING_W-1:0] waiting;
		logic                 full;
	} result_t;

endpackage

>>> rtl/core/marker_frame_splitter_queue.sv
// ----------------------------------------------------------------------------
// marker_frame_splitter_queue
// Cuts start/end delimited frames from a byte stream into a ring of slots
// and returns the oldest frame one byte per read request.
// ----------------------------------------------------------------------------
// One input transfer is taken per clock cycle while s_axis_tready is high. Each
// transfer does at most one access to the single-port frame memory (a byte
// write or a byte read), and all slot pointers, counts and lengths are updated
// in the cycle the transfer is accepted, so back-to-back transfers never wait
// on each other. The memory read data is registered, and the finished result
// passes through a result register into a three-entry output queue before it
// appears on the master side. s_axis_tready depends only on registered
// occupancy. The frame memory needs no clearing after reset.
module marker_frame_splitter_queue (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [mfsq_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  logic [mfsq_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [7:0]                          s_axis_tdata,  // [7:0] data_byte
	input  logic                                s_axis_tuser,  // [0] mode
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [15:0]                         m_axis_tdata,  // [7:0] out_byte,
	                                                           // [12:8] frames_waiting,
	                                                           // [13] queue_full
	output logic                                m_axis_tlast,  // frame_end
	output logic [2:0]                          m_axis_tuser   // [2:0] status
);
	import mfsq_pkg::*;

	localparam int FIFO_DEPTH = 3;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

	logic [7:0]       start_marker_q, end_marker_q;
	logic [7:0]       store_mem [STORE_SIZE];
	logic [7:0]       rd_data_q;
	logic [LEN_W-1:0] slot_len_q [SLOT_COUNT];

	logic [SLOT_W-1:0] write_slot_q, read_slot_q;
	logic [CNT_W-1:0]  held_q;
	logic              in_frame_q;
	logic [LEN_W-1:0]  build_len_q;
	logic [OFF_W-1:0]  read_off_q;
	logic              full_q;

	logic    valid_s1;
	result_t res_s1;

	result_t           fifo_q [FIFO_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [FCNT_W-1:0] fcnt_q;

	logic              acc, mode;
	logic [7:0]        din;
	logic              mem_we, mem_re;
	logic [ADDR_W-1:0] mem_addr;
	logic              len_we;

	logic [SLOT_W-1:0] write_slot_d, read_slot_d;
	logic [CNT_W-1:0]  held_d;
	logic              in_frame_d;
	logic [LEN_W-1:0]  build_len_d;
	logic [OFF_W-1:0]  read_off_d;
	logic              full_d;
	status_t           status_d;
	logic              fend_d;
	logic [LEN_W-1:0]  next_off;
	logic              push, pop;
	result_t           push_res;

	function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
		next_slot = (s == SLOT_W'(SLOT_COUNT - 1)) ? '0 : s + 1'b1;
	endfunction

	assign mode = s_axis_tuser;
	assign din  = s_axis_tdata;
	assign acc  = s_axis_tvalid && s_axis_tready;

	assign s_axis_tready = ({1'b0, fcnt_q} + {{FCNT_W{1'b0}}, valid_s1})
		< (FCNT_W + 1)'(FIFO_DEPTH);

	assign next_off = LEN_W'(read_off_q) + 1'b1;

	always_comb begin
		write_slot_d = write_slot_q;
		read_slot_d  = read_slot_q;
		held_d       = held_q;
		in_frame_d   = in_frame_q;
		build_len_d  = build_len_q;
		read_off_d   = read_off_q;
		full_d       = full_q;
		status_d     = ST_IGNORED;
		fend_d       = 1'b0;
		mem_we       = 1'b0;
		mem_re       = 1'b0;
		len_we       = 1'b0;
		mem_addr     = ADDR_W'(write_slot_q) * ADDR_W'(SLOT_BYTES)
			+ ADDR_W'(build_len_q);
		if (!mode) begin
			if (din == start_marker_q) begin
				build_len_d = '0;
				if (held_q == CNT_W'(SLOT_COUNT)) begin
					in_frame_d = 1'b0;
					full_d     = 1'b1;
					status_d   = ST_DROP_FULL;
				end else begin
					in_frame_d  = 1'b1;
					mem_we      = 1'b1;
					mem_addr    = ADDR_W'(write_slot_q) * ADDR_W'(SLOT_BYTES);
					build_len_d = LEN_W'(1);
					status_d    = ST_TAKEN;
				end
			end else if (in_frame_q) begin
				if (build_len_q >= LEN_W'(SLOT_BYTES)) begin
					in_frame_d  = 1'b0;
					build_len_d = '0;
					status_d    = ST_DROP_LONG;
				end else begin
					mem_we      = 1'b1;
					build_len_d = build_len_q + 1'b1;
					status_d    = ST_TAKEN;
					if (din == end_marker_q) begin
						len_we       = 1'b1;
						write_slot_d = next_slot(write_slot_q);
						held_d       = held_q + 1'b1;
						in_frame_d   = 1'b0;
						build_len_d  = '0;
						status_d     = ST_STORED;
					end
				end
			end
		end else begin
			mem_addr = ADDR_W'(read_slot_q) * ADDR_W'(SLOT_BYTES) + ADDR_W'(read_off_q);
			if (held_q == '0) begin
				status_d = ST_READ_EMPTY;
			end else begin
				mem_re     = 1'b1;
				status_d   = ST_READ_BYTE;
				read_off_d = OFF_W'(next_off);
				if (next_off >= slot_len_q[read_slot_q]) begin
					fend_d      = 1'b1;
					read_off_d  = '0;
					read_slot_d = next_slot(read_slot_q);
					held_d      = held_q - 1'b1;
					full_d      = 1'b0;
				end
			end
		end
	end

	// the frame memory takes at most one access per accepted transfer
	always_ff @(posedge clk) begin
		if (acc && mem_we)
			store_mem[mem_addr] <= din;
		if (acc && mem_re)
			rd_data_q <= store_mem[mem_addr];
	end

	always_ff @(posedge clk) begin
		if (acc && len_we)
			slot_len_q[write_slot_q] <= build_len_q + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_marker_q <= START_MARKER_RESET;
			end_marker_q   <= END_MARKER_RESET;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_START_MARKER: start_marker_q <= cfg_wdata;
				REG_END_MARKER:   end_marker_q   <= cfg_wdata;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_slot_q <= '0;
			read_slot_q  <= '0;
			held_q       <= '0;
			in_frame_q   <= 1'b0;
			build_len_q  <= '0;
			read_off_q   <= '0;
			full_q       <= 1'b0;
			valid_s1     <= 1'b0;
		end else begin
			valid_s1 <= acc;
			if (acc) begin
				write_slot_q <= write_slot_d;
				read_slot_q  <= read_slot_d;
				held_q       <= held_d;
				in_frame_q   <= in_frame_d;
				build_len_q  <= build_len_d;
				read_off_q   <= read_off_d;
				full_q       <= full_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			res_s1.status    <= status_d;
			res_s1.data      <= '0;
			res_s1.frame_end <= fend_d;
			res_s1.waiting   <= WAITING_W'(held_d);
			res_s1.full      <= full_d;
		end
	end

	// output queue
	assign push = valid_s1;
	assign pop  = m_axis_tvalid && m_axis_tready;

	always_comb begin
		push_res      = res_s1;
		push_res.data = (res_s1.status == ST_READ_BYTE) ? rd_data_q : '0;
	end

	always_ff @(posedge clk) begin
		if (push)
			fifo_q[wr_ptr_q] <= push_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fcnt_q   <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			fcnt_q <= fcnt_q + FCNT_W'(push) - FCNT_W'(pop);
		end
	end

	assign m_axis_tvalid = (fcnt_q != '0);
	assign m_axis_tdata  = {2'b00, fifo_q[rd_ptr_q].full, fifo_q[rd_ptr_q].waiting,
		fifo_q[rd_ptr_q].data};
	assign m_axis_tlast  = fifo_q[rd_ptr_q].frame_end;
	assign m_axis_tuser  = fifo_q[rd_ptr_q].status;

	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= CNT_W'(SLOT_COUNT))
		else $error("held frame count above slot count");

	a_frame_has_slot: assert property (@(posedge clk) disable iff (!arst_n)
		in_frame_q |-> held_q < CNT_W'(SLOT_COUNT))
		else $error("frame under construction without a free slot");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (fcnt_q < FCNT_W'(FIFO_DEPTH)) || pop)
		else $error("output queue overflow");

	a_empty_read: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && mode && held_q == '0) |=> (valid_s1 && res_s1.status == ST_READ_EMPTY))
		else $error("read on empty queue not reported");

	a_store_single_access: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re))
		else $error("frame memory read and write in one cycle");

endmodule
